>>> hdl/fdtd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdtd_pkg
// Shared types, constants and the mode decode for the electric field update.
// ----------------------------------------------------------------------------
package fdtd_pkg;

    localparam int DataW  = 32;
    localparam int EpsW   = 31;
    localparam int DtW    = 31;
    localparam int ModeW  = 3;
    localparam int CompW  = 2;
    localparam int FracW  = 16;
    // Magnitude of dt*dipole is below 2^62, so 63 quotient bits cover it.
    localparam int DivW   = 63;
    // Width of the three product terms summed after the Q16 shift.
    localparam int AccW   = 52;
    localparam int AddrW  = 3;

    localparam logic [0:0] RegSimMode  = 1'b0;
    localparam logic [0:0] RegTimeStep = 1'b1;

    localparam logic [CompW-1:0] CompX = 2'd0;
    localparam logic [CompW-1:0] CompY = 2'd1;
    localparam logic [CompW-1:0] CompZ = 2'd2;

    localparam logic [ModeW-1:0] Mode3d   = 3'd0;
    localparam logic [ModeW-1:0] ModeOnlyX = 3'd1;
    localparam logic [ModeW-1:0] ModeOnlyY = 3'd2;
    localparam logic [ModeW-1:0] ModeOnlyZ = 3'd3;
    localparam logic [ModeW-1:0] ModeHx   = 3'd4;
    localparam logic [ModeW-1:0] ModeHy   = 3'd5;
    localparam logic [ModeW-1:0] ModeHz   = 3'd6;

    typedef struct packed {
        logic [CompW-1:0]        component;
        logic signed [DataW-1:0] e_old;
        logic signed [DataW-1:0] decay_coef;
        logic signed [DataW-1:0] curl_coef_a;
        logic signed [DataW-1:0] curl_coef_b;
        logic signed [DataW-1:0] h_a_here;
        logic signed [DataW-1:0] h_a_back;
        logic signed [DataW-1:0] h_b_here;
        logic signed [DataW-1:0] h_b_back;
        logic signed [DataW-1:0] dipole_value;
        logic [EpsW-1:0]         permittivity;
        logic [1:0]              edge_mask;
    } t_in;

    typedef struct packed {
        logic signed [DataW-1:0] e_new;
        logic                    updated;
        logic                    overflow;
    } t_out;

    // Decoded term usage for one item.
    typedef struct packed {
        logic use_a;
        logic use_b;
        logic upd;
    } t_use;

    // Data that rides along the divider stages.
    typedef struct packed {
        logic                    neg;
        logic [EpsW-1:0]         eps;
        logic signed [AccW-1:0]  acc;
        logic signed [DataW-1:0] e_old;
        logic                    upd;
    } t_side;

    function automatic t_use term_use(input logic [ModeW-1:0] mode,
                                      input logic [CompW-1:0] comp);
        t_use u;
        u = '0;
        unique case (mode)
            Mode3d: begin
                if (comp != 2'd3) u = '{1'b1, 1'b1, 1'b1};
            end
            ModeOnlyX: begin
                if (comp == CompX) u = '{1'b1, 1'b1, 1'b1};
            end
            ModeOnlyY: begin
                if (comp == CompY) u = '{1'b1, 1'b1, 1'b1};
            end
            ModeOnlyZ: begin
                if (comp == CompZ) u = '{1'b1, 1'b1, 1'b1};
            end
            ModeHx: begin
                if (comp == CompY) u = '{1'b1, 1'b0, 1'b1};
                if (comp == CompZ) u = '{1'b0, 1'b1, 1'b1};
            end
            ModeHy: begin
                if (comp == CompX) u = '{1'b0, 1'b1, 1'b1};
                if (comp == CompZ) u = '{1'b1, 1'b0, 1'b1};
            end
            ModeHz: begin
                if (comp == CompX) u = '{1'b1, 1'b0, 1'b1};
                if (comp == CompY) u = '{1'b0, 1'b1, 1'b1};
            end
            default: u = '0;
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

>>> hdl/fdtd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdtd_front
// Three stages: decode and differences, products, Q16 shift and sum.
// ----------------------------------------------------------------------------
module fdtd_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_vld,
    input  wire fdtd_pkg::t_in                     i_data,
    input  wire logic [fdtd_pkg::ModeW-1:0]        i_mode,
    input  wire logic [fdtd_pkg::DtW-1:0]          i_dt,
    output logic                                   o_vld,
    output logic [fdtd_pkg::DivW-1:0]              o_num,
    output fdtd_pkg::t_side                        o_side
);

    localparam int DW = fdtd_pkg::DataW;

    fdtd_pkg::t_use n_use;

    // Stage 1
    logic                         r1_vld;
    logic                         r1_upd;
    logic signed [DW-1:0]         r1_e_old, r1_ca, r1_cba, r1_cbb, r1_dip;
    logic signed [DW:0]           r1_da, r1_db;
    logic [fdtd_pkg::EpsW-1:0]    r1_eps;
    logic [fdtd_pkg::DtW-1:0]     r1_dt;

    // Stage 2
    logic                         r2_vld;
    logic                         r2_upd;
    logic signed [DW-1:0]         r2_e_old;
    logic [fdtd_pkg::EpsW-1:0]    r2_eps;
    logic signed [2*DW-1:0]       r2_pca, r2_psrc;
    logic signed [2*DW:0]         r2_pa, r2_pb;

    logic signed [2*DW-fdtd_pkg::FracW-1:0] n_fca;
    logic signed [2*DW-fdtd_pkg::FracW:0]   n_fa, n_fb;
    logic signed [fdtd_pkg::AccW-1:0]       n_acc;
    logic [2*DW-1:0]                        n_mag;

    assign n_use = fdtd_pkg::term_use(i_mode, i_data.component);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            o_vld  <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            o_vld  <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_upd   <= n_use.upd;
            r1_e_old <= i_data.e_old;
            r1_ca    <= i_data.decay_coef;
            r1_cba   <= i_data.curl_coef_a;
            r1_cbb   <= i_data.curl_coef_b;
            r1_dip   <= i_data.dipole_value;
            r1_dt    <= i_dt;
            // A term that is off contributes a zero difference.
            r1_da <= (n_use.use_a && i_data.edge_mask[0])
                ? ({i_data.h_a_here[DW-1], i_data.h_a_here}
                   - {i_data.h_a_back[DW-1], i_data.h_a_back})
                : '0;
            r1_db <= (n_use.use_b && i_data.edge_mask[1])
                ? ({i_data.h_b_here[DW-1], i_data.h_b_here}
                   - {i_data.h_b_back[DW-1], i_data.h_b_back})
                : '0;
            r1_eps <= (i_data.permittivity == '0)
                ? fdtd_pkg::EpsW'(1) : i_data.permittivity;

            r2_upd   <= r1_upd;
            r2_e_old <= r1_e_old;
            r2_eps   <= r1_eps;
            r2_pca   <= r1_ca * r1_e_old;
            r2_pa    <= r1_cba * r1_da;
            r2_pb    <= r1_cbb * r1_db;
            r2_psrc  <= $signed({1'b0, r1_dt}) * r1_dip;

            o_num        <= n_mag[fdtd_pkg::DivW-1:0];
            o_side.neg   <= r2_psrc[2*DW-1];
            o_side.eps   <= r2_eps;
            o_side.acc   <= n_acc;
            o_side.e_old <= r2_e_old;
            o_side.upd   <= r2_upd;
        end
    end

    // Dropping the low 16 bits of a two's-complement value rounds to minus infinity.
    assign n_fca = r2_pca[2*DW-1:fdtd_pkg::FracW];
    assign n_fa  = r2_pa[2*DW:fdtd_pkg::FracW];
    assign n_fb  = r2_pb[2*DW:fdtd_pkg::FracW];
    assign n_acc = fdtd_pkg::AccW'(n_fca) + fdtd_pkg::AccW'(n_fa)
                 - fdtd_pkg::AccW'(n_fb);
    assign n_mag = r2_psrc[2*DW-1] ? (2*DW)'(-r2_psrc) : r2_psrc;

endmodule
`default_nettype wire

>>> hdl/fdtd_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdtd_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module fdtd_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_vld,
    input  wire logic [fdtd_pkg::DivW-1:0]     i_num,
    input  wire fdtd_pkg::t_side               i_side,
    output logic                               o_vld,
    output logic [fdtd_pkg::DivW-1:0]          o_quo,
    output fdtd_pkg::t_side                    o_side
);

    localparam int N  = fdtd_pkg::DivW;
    localparam int EW = fdtd_pkg::EpsW;

    // Numerator bits leave at the top of r_nq while quotient bits enter below.
    logic [N-1:0]    r_vld;
    logic [N-1:0]    r_nq   [N];
    logic [EW-1:0]   r_rem  [N];
    fdtd_pkg::t_side r_side [N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [N-1:0]    p_nq;
        logic [EW-1:0]   p_rem;
        fdtd_pkg::t_side p_side;
        logic            p_vld;
        logic [EW:0]     n_trial;
        logic [EW:0]     n_diff;
        logic            n_ge;

        if (s == 0) begin : g_first
            assign p_nq   = i_num;
            assign p_rem  = '0;
            assign p_side = i_side;
            assign p_vld  = i_vld;
        end else begin : g_next
            assign p_nq   = r_nq[s-1];
            assign p_rem  = r_rem[s-1];
            assign p_side = r_side[s-1];
            assign p_vld  = r_vld[s-1];
        end

        assign n_trial = {p_rem, p_nq[N-1]};
        assign n_diff  = n_trial - {1'b0, p_side.eps};
        assign n_ge    = n_trial >= {1'b0, p_side.eps};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nq[s]   <= {p_nq[N-2:0], n_ge};
                r_rem[s]  <= n_ge ? n_diff[EW-1:0] : n_trial[EW-1:0];
                r_side[s] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[N-1];
    assign o_quo  = r_nq[N-1];
    assign o_side = r_side[N-1];

endmodule
`default_nettype wire

>>> hdl/fdtd_electric_field_cell_update_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdtd_electric_field_cell_update_core
// Lossy Yee electric field update for one cell component per transfer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  in        input      i_in_valid / o_in_stall    i_in_data  (t_in)
//  out       output     o_out_valid / i_out_stall  o_out_data (t_out)
//  cfg       input      APB psel/penable/pready    paddr, pwdata, prdata
//
//  One transfer is accepted per cycle unless the output is stalled. The path runs
//  through three front stages (decode, multiply, sum), 63 divider stages for
//  dt*dipole/eps with one quotient bit each, and the saturating output register.
//  Reset is synchronous and clears the valid bits and the mode and time-step registers.
//  A stalled output freezes the whole pipeline, so o_in_stall follows it.
// ----------------------------------------------------------------------------
module fdtd_electric_field_cell_update_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire fdtd_pkg::t_in                 i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output fdtd_pkg::t_out                     o_out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fdtd_pkg::AddrW-1:0]    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int W = fdtd_pkg::AccW + 2;

    logic [fdtd_pkg::ModeW-1:0] r_mode;
    logic [fdtd_pkg::DtW-1:0]   r_dt;
    logic                       n_en;

    logic                       f_vld, d_vld;
    logic [fdtd_pkg::DivW-1:0]  f_num, d_quo;
    fdtd_pkg::t_side            f_side, d_side;

    logic signed [W+10:0]       n_sum;
    logic signed [W+10:0]       n_q;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
            r_dt   <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                fdtd_pkg::RegSimMode:  r_mode <= pwdata[fdtd_pkg::ModeW-1:0];
                fdtd_pkg::RegTimeStep: r_dt   <= pwdata[fdtd_pkg::DtW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            fdtd_pkg::RegSimMode:  prdata = {29'd0, r_mode};
            fdtd_pkg::RegTimeStep: prdata = {1'b0, r_dt};
            default:               prdata = '0;
        endcase
    end

    assign n_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !n_en;

    fdtd_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (n_en),
        .i_vld  (i_in_valid),
        .i_data (i_in_data),
        .i_mode (r_mode),
        .i_dt   (r_dt),
        .o_vld  (f_vld),
        .o_num  (f_num),
        .o_side (f_side)
    );

    fdtd_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (n_en),
        .i_vld  (f_vld),
        .i_num  (f_num),
        .i_side (f_side),
        .o_vld  (d_vld),
        .o_quo  (d_quo),
        .o_side (d_side)
    );

    // The quotient is truncated toward zero, so the sign is applied after division.
    assign n_q   = d_side.neg ? -$signed({2'b00, d_quo}) : $signed({2'b00, d_quo});
    assign n_sum = (W+11)'(d_side.acc) - n_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (n_en) begin
            o_out_valid <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            if (!d_side.upd) begin
                o_out_data <= '{d_side.e_old, 1'b0, 1'b0};
            end else if (n_sum > (W+11)'(32'sh7fffffff)) begin
                o_out_data <= '{32'sh7fffffff, 1'b1, 1'b1};
            end else if (n_sum < -(W+11)'(64'sh80000000)) begin
                o_out_data <= '{32'sh80000000, 1'b1, 1'b1};
            end else begin
                o_out_data <= '{n_sum[31:0], 1'b1, 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/fdtd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdtd_checker
// Port-level checks on the electric field update core.
// ----------------------------------------------------------------------------
module fdtd_checker (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            o_in_stall,
    input  wire logic            o_out_valid,
    input  wire logic            i_out_stall,
    input  wire fdtd_pkg::t_out  o_out_data,
    input  wire logic            pready
);

    // The input side stalls only when a finished result is held back.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without an output stall");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_pass_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.updated) |-> !o_out_data.overflow)
        else $error("overflow on a passed-through component");

    a_ovf_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.overflow) |->
        (o_out_data.e_new == 32'sh7fffffff || o_out_data.e_new == 32'sh80000000))
        else $error("overflow without a clamped value");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind fdtd_electric_field_cell_update_core fdtd_checker u_fdtd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data),
    .pready     (pready)
);
`default_nettype wire
